@@ design/selective_background_update_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Selective background update unit: assertion macros
// Shared assertion forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_BACKGROUND_UPDATE_UNIT_MACROS_SVH
`define SELECTIVE_BACKGROUND_UPDATE_UNIT_MACROS_SVH

// same-cycle implication
`define SBU_ASSERT_IMPL(label, ante, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define SBU_ASSERT_NEXT(label, ante, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (conseq)) \
        else $error(msg);

`endif

@@ design/sbu_pkg.sv @@
// ----------------------------------------------------------------------------
// Selective background update unit: package
// Field widths, command and register codes, and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbu_pkg;

    localparam int IDX_W       = 17;
    localparam int GRAY_W      = 8;
    localparam int BGV_W       = 16;
    localparam int THR_W       = 16;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_SHIFT = 16;
    localparam int GRAY_MAX    = 255;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 17;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_MOTION_THRESHOLD = 2'd0;
    localparam cfg_addr_t REG_ALPHA_STILL      = 2'd1;
    localparam cfg_addr_t REG_ALPHA_MOVING     = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET    = 16'd5120;
    localparam logic [ALPHA_W-1:0] ALPHA_STILL_RESET  = 17'd6554;
    localparam logic [ALPHA_W-1:0] ALPHA_MOVING_RESET = 17'd655;

endpackage

@@ design/sbu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old data
// when both ports hit the same address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/selective_background_update_unit.sv @@
// ----------------------------------------------------------------------------
// Selective background update unit
// Per-pixel running-average background with a motion mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one transaction per pixel. command load writes a
//   Q8.FRAC_BITS background value into the frame store, saturated to 255.0;
//   command update brings a gray level, compares it with the stored value,
//   adds alpha * difference and writes the clamped sum back. Indexes at or
//   above FRAME_PIXELS are accepted and dropped.
//   Result channel (m_*): one transaction per in-range update, none per load.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr; write only
//   while the unit is idle.
//   Result path: input stage register, then the result register.
//   Throughput: one transaction per cycle unless stalled; a store entry's
//   read-modify-write is one RAM read, one compute stage and one RAM write,
//   with a one-entry bypass so the same pixel may follow in the next cycle.
//   Reset: registers return to their defaults; store contents are undefined
//   until loaded and need no clearing pass.
//   Stall: a held result keeps its value; loads pass, and one more update is
//   taken into the compute stage, then s_ready drops until m_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "selective_background_update_unit_macros.svh"

module selective_background_update_unit #(
    parameter int FRAME_PIXELS = 131072,
    parameter int FRAC_BITS    = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [sbu_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sbu_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [sbu_pkg::IDX_W-1:0]         s_pixel_index,
    input  logic [sbu_pkg::GRAY_W-1:0]        s_gray_level,
    input  logic [sbu_pkg::BGV_W-1:0]         s_background_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sbu_pkg::IDX_W-1:0]         m_result_index,
    output logic                              m_moving,
    output logic [sbu_pkg::BGV_W-1:0]         m_new_background
);

    import sbu_pkg::*;

    localparam int BG_W    = GRAY_W + FRAC_BITS;
    localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int LD_W    = (BG_W > BGV_W) ? BG_W : BGV_W;
    localparam int CMP_W   = (BG_W > THR_W) ? BG_W : THR_W;
    localparam int DIFF_W  = BG_W + 1;
    localparam int PROD_W  = DIFF_W + ALPHA_W + 1;
    localparam int DELTA_W = PROD_W - ALPHA_SHIFT;
    localparam int SUM_W   = DELTA_W + 1;
    localparam logic [BG_W-1:0] BG_MAX = BG_W'(GRAY_MAX) << FRAC_BITS;

    // configuration
    logic [THR_W-1:0]   thr_reg;
    logic [ALPHA_W-1:0] alpha_still_reg;
    logic [ALPHA_W-1:0] alpha_moving_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg          <= THRESHOLD_RESET;
            alpha_still_reg  <= ALPHA_STILL_RESET;
            alpha_moving_reg <= ALPHA_MOVING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MOTION_THRESHOLD: thr_reg          <= THR_W'(cfg_wdata);
                REG_ALPHA_STILL:      alpha_still_reg  <= ALPHA_W'(cfg_wdata);
                REG_ALPHA_MOVING:     alpha_moving_reg <= ALPHA_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // input stage
    logic              s_fire;
    logic              in_range;
    logic              p1_valid_reg;
    logic              p1_valid_next;
    logic              p1_cmd_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic [GRAY_W-1:0] p1_gray_reg;
    logic [BGV_W-1:0]  p1_bgv_reg;
    logic              p1_emit;
    logic              p1_adv;
    logic              p1_done;
    logic              m_valid_reg;

    assign in_range      = 32'(s_pixel_index) < 32'(FRAME_PIXELS);
    assign p1_emit       = (p1_cmd_reg == CMD_UPDATE);
    assign p1_adv        = !p1_valid_reg || !p1_emit || !m_valid_reg || m_ready;
    assign p1_done       = p1_valid_reg && p1_adv;
    assign s_ready       = p1_adv;
    assign s_fire        = s_valid && s_ready;
    assign p1_valid_next = s_fire && in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_cmd_reg  <= s_command;
            p1_idx_reg  <= s_pixel_index;
            p1_gray_reg <= s_gray_level;
            p1_bgv_reg  <= s_background_value;
        end
    end

    // frame store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BG_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BG_W-1:0]   ram_rdata;

    assign ram_we    = p1_done;
    assign ram_waddr = ADDR_W'(p1_idx_reg);
    assign ram_raddr = ADDR_W'(s_pixel_index);

    sbu_ram #(
        .WIDTH (BG_W),
        .DEPTH (FRAME_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (p1_valid_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // bypass of the last write
    logic             wb_valid_reg;
    logic [IDX_W-1:0] wb_idx_reg;
    logic [BG_W-1:0]  wb_data_reg;
    logic             fwd_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else if (ram_we) begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            wb_idx_reg  <= p1_idx_reg;
            wb_data_reg <= ram_wdata;
        end
    end

    assign fwd_sel = wb_valid_reg && (wb_idx_reg == p1_idx_reg);

    // update
    logic        [BG_W-1:0]    bg_cur;
    logic        [BG_W-1:0]    gray_fx;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_neg;
    logic        [BG_W-1:0]    mag;
    logic                      moving;
    logic        [ALPHA_W-1:0] alpha;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic        [BG_W-1:0]    bg_upd;
    logic        [LD_W-1:0]    ld_ext;
    logic        [BG_W-1:0]    bg_load;

    always_comb begin
        bg_cur   = fwd_sel ? wb_data_reg : ram_rdata;
        gray_fx  = BG_W'(p1_gray_reg) << FRAC_BITS;
        diff     = $signed({1'b0, gray_fx}) - $signed({1'b0, bg_cur});
        diff_neg = -diff;
        mag      = BG_W'(diff[DIFF_W-1] ? diff_neg : diff);
        moving   = CMP_W'(mag) >= CMP_W'(thr_reg);
        alpha    = moving ? alpha_moving_reg : alpha_still_reg;
        prod     = PROD_W'($signed({1'b0, alpha})) * PROD_W'(diff);
        delta    = DELTA_W'(prod >>> ALPHA_SHIFT);
        sum      = SUM_W'($signed({1'b0, bg_cur})) + SUM_W'(delta);
        if (sum[SUM_W-1]) begin
            bg_upd = '0;
        end else if (sum > SUM_W'($signed({1'b0, BG_MAX}))) begin
            bg_upd = BG_MAX;
        end else begin
            bg_upd = BG_W'(sum);
        end
        ld_ext    = LD_W'(p1_bgv_reg);
        bg_load   = (ld_ext > LD_W'(BG_MAX)) ? BG_MAX : BG_W'(ld_ext);
        ram_wdata = p1_emit ? bg_upd : bg_load;
    end

    // result register
    logic [IDX_W-1:0] m_index_reg;
    logic             m_moving_reg;
    logic [BGV_W-1:0] m_bg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_done && p1_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_done && p1_emit) begin
            m_index_reg  <= p1_idx_reg;
            m_moving_reg <= moving;
            m_bg_reg     <= BGV_W'(bg_upd);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_index   = m_index_reg;
    assign m_moving         = m_moving_reg;
    assign m_new_background = m_bg_reg;

    `SBU_ASSERT_IMPL(a_stall_cause, !s_ready,
                     m_valid_reg && !m_ready && p1_valid_reg && p1_emit,
                     "input stalled without a held result")
    `SBU_ASSERT_NEXT(a_result_follows, p1_done && p1_emit, m_valid_reg,
                     "update finished without a result")
    `SBU_ASSERT_NEXT(a_bypass_taken,
                     ram_we && p1_valid_next && (ram_waddr == ram_raddr), fwd_sel,
                     "same-pixel follow-up missed the bypass")
    `SBU_ASSERT_IMPL(a_store_range, ram_we, ram_wdata <= BG_MAX,
                     "store write above 255.0")

endmodule
